// ----- hdl/assert_macros.svh -----
// Concurrent assertion helpers, clocked on aclk and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the property in the same cycle.
`define ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// The condition implies the property in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/rpncalc_pkg.sv -----
package rpncalc_pkg;

    localparam int WORD_W = 32;
    localparam int ITER_W = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ITER_W-1:0] iter_t;

    // last step of the shift-add multiply and of the restoring divide
    localparam iter_t MUL_LAST = iter_t'(WORD_W - 1);
    localparam iter_t DIV_LAST = iter_t'(WORD_W - 2);

    localparam word_t Q_MAX = 32'h7fff_ffff;
    localparam word_t Q_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        MODE_PUSH = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV_CHK,
        ST_DIV,
        ST_ROUND,
        ST_FINISH
    } state_t;

    // apply sign to an unsigned magnitude, saturating to the 32-bit signed range
    function automatic word_t sat_mag(input logic [63:0] mag, input logic neg);
        word_t res;
        if (|mag[63:WORD_W-1]) begin
            res = neg ? Q_MIN : Q_MAX;
        end else begin
            res = neg ? (word_t'(0) - mag[WORD_W-1:0]) : mag[WORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hdl/rpn_four_level_stack_calculator_unit.sv -----
// Reverse Polish calculator on signed fixed-point words (FRAC_BITS fraction bits) with a
// STACK_DEPTH-entry operand stack, zero after reset. A push word (tuser = 0) produces no
// result. An operator word (1 add, 2 subtract, 3 multiply, 4 divide) combines the second
// entry with the bottom entry, pops the stack, writes the saturated result to the bottom
// and sends it out; a divide by zero sends zero with status 1 and keeps the stack. Codes
// 5 to 7 are dropped. The four operations share one 64-bit adder under a small sequencer:
// add and subtract finish after setup, multiply runs 32 shift-add steps plus rounding,
// divide 31 restoring steps plus overflow check and sign fix; a divide by zero or an
// overflowing divide skips the steps. s_tready is low while an operator word is in progress;
// one finished result can wait in the output register while the next word is accepted.
`include "assert_macros.svh"

module rpn_four_level_stack_calculator_unit #(
    parameter int STACK_DEPTH = 4,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rpncalc_pkg::word_t   s_tdata,   // [31:0] operand
    input  logic [2:0]           s_tuser,   // [2:0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output rpncalc_pkg::word_t   m_tdata,   // [31:0] result
    output logic                 m_tuser    // [0] status
);
    import rpncalc_pkg::*;

    localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

    state_t      state_reg, state_next;
    mode_t       op_reg, op_next;
    logic        neg_reg, neg_next;
    logic        err_reg, err_next;
    iter_t       cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] aux_reg, aux_next;
    logic [32:0] den_reg, den_next;
    word_t       res_reg, res_next;
    word_t       stack_reg [STACK_DEPTH];
    word_t       stack_next [STACK_DEPTH];
    logic        out_valid_reg, out_valid_next;
    word_t       out_data_reg, out_data_next;
    logic        out_status_reg, out_status_next;

    logic        in_acc;
    mode_t       in_mode;
    logic        in_is_op;
    word_t       left, right;
    word_t       mag_l, mag_r;
    logic [63:0] add_a, add_b;
    logic        add_cin;
    logic [64:0] add_sum;
    logic        out_free;
    logic        commit;
    logic [33:0] div_trial;
    logic [63:0] mag_round;
    logic        add_ovf;

    assign in_acc   = s_tvalid && s_tready;
    assign in_mode  = mode_t'(s_tuser);
    assign in_is_op = (in_mode == MODE_ADD) || (in_mode == MODE_SUB) ||
                      (in_mode == MODE_MUL) || (in_mode == MODE_DIV);
    assign left     = stack_reg[1];
    assign right    = stack_reg[0];
    assign mag_l    = left[WORD_W-1]  ? (word_t'(0) - left)  : left;
    assign mag_r    = right[WORD_W-1] ? (word_t'(0) - right) : right;
    assign out_free = !out_valid_reg || m_tready;
    assign commit   = (state_reg == ST_FINISH) && out_free;

    // partial remainder with the next numerator bit shifted in
    assign div_trial = {acc_reg[32:0], aux_reg[30]};

    // the shared unit: 64-bit add with carry in and carry out
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + 65'(add_cin);
    assign add_ovf = !((&add_sum[63:WORD_W-1]) || !(|add_sum[63:WORD_W-1]));

    assign mag_round = (op_reg == MODE_MUL) ? (add_sum[63:0] >> FRAC_BITS)
                                            : 64'(aux_reg[30:0]);

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            ST_SETUP: begin
                case (op_reg)
                    MODE_ADD: begin
                        add_a = {{32{left[WORD_W-1]}}, left};
                        add_b = {{32{right[WORD_W-1]}}, right};
                    end
                    MODE_SUB: begin
                        add_a   = {{32{left[WORD_W-1]}}, left};
                        add_b   = ~{{32{right[WORD_W-1]}}, right};
                        add_cin = 1'b1;
                    end
                    MODE_DIV: begin
                        // 2 * (|left| << FRAC_BITS) + |right|, for round half up
                        add_a = 64'(mag_l) << (FRAC_BITS + 1);
                        add_b = 64'(mag_r);
                    end
                    default: ;
                endcase
            end
            ST_MUL: begin
                add_a = acc_reg;
                add_b = den_reg[0] ? aux_reg : 64'd0;
            end
            ST_ROUND: begin
                add_a = acc_reg;
                add_b = HALF;
            end
            ST_DIV_CHK: begin
                // quotient reaches 2^31 when the upper numerator bits reach the divisor
                add_a   = 64'(aux_reg[63:31]);
                add_b   = ~64'(den_reg);
                add_cin = 1'b1;
            end
            ST_DIV: begin
                add_a   = 64'(div_trial);
                add_b   = ~64'(den_reg);
                add_cin = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && in_is_op) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                case (op_reg)
                    MODE_MUL: state_next = ST_MUL;
                    MODE_DIV: state_next = (right == '0) ? ST_FINISH : ST_DIV_CHK;
                    default:  state_next = ST_FINISH;
                endcase
            end
            ST_MUL: begin
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_ROUND;
                end
            end
            ST_DIV_CHK: begin
                state_next = add_sum[64] ? ST_FINISH : ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next         = op_reg;
        neg_next        = neg_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        aux_next        = aux_reg;
        den_next        = den_reg;
        res_next        = res_reg;
        stack_next      = stack_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            ST_IDLE: begin
                err_next = 1'b0;
                if (in_acc) begin
                    if (in_mode == MODE_PUSH) begin
                        for (int i = STACK_DEPTH - 1; i > 0; i--) begin
                            stack_next[i] = stack_reg[i-1];
                        end
                        stack_next[0] = s_tdata;
                    end else if (in_is_op) begin
                        op_next = in_mode;
                    end
                end
            end
            ST_SETUP: begin
                neg_next = left[WORD_W-1] ^ right[WORD_W-1];
                cnt_next = '0;
                case (op_reg)
                    MODE_ADD, MODE_SUB: begin
                        res_next = add_ovf ? (add_sum[63] ? Q_MIN : Q_MAX)
                                           : add_sum[WORD_W-1:0];
                    end
                    MODE_MUL: begin
                        acc_next = '0;
                        aux_next = 64'(mag_l);
                        den_next = {1'b0, mag_r};
                    end
                    MODE_DIV: begin
                        if (right == '0) begin
                            err_next = 1'b1;
                        end else begin
                            aux_next = add_sum[63:0];
                            den_next = {mag_r, 1'b0};
                        end
                    end
                    default: ;
                endcase
            end
            ST_MUL: begin
                acc_next = add_sum[63:0];
                aux_next = {aux_reg[62:0], 1'b0};
                den_next = {1'b0, den_reg[32:1]};
                cnt_next = cnt_reg + iter_t'(1);
            end
            ST_DIV_CHK: begin
                cnt_next = '0;
                if (add_sum[64]) begin
                    res_next = neg_reg ? Q_MIN : Q_MAX;
                end else begin
                    acc_next = 64'(aux_reg[63:31]);
                end
            end
            ST_DIV: begin
                acc_next = add_sum[64] ? 64'(add_sum[33:0]) : 64'(div_trial);
                aux_next = {aux_reg[62:0], add_sum[64]};
                cnt_next = cnt_reg + iter_t'(1);
            end
            ST_ROUND: begin
                res_next = sat_mag(mag_round, neg_reg);
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = err_reg ? word_t'(0) : res_reg;
                    out_status_next = err_reg;
                    if (!err_reg) begin
                        for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                            stack_next[i] = stack_reg[i+1];
                        end
                        stack_next[STACK_DEPTH-1] = '0;
                        stack_next[0]             = res_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STACK_DEPTH; i++) begin
                stack_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            stack_reg     <= stack_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        neg_reg        <= neg_next;
        err_reg        <= err_next;
        cnt_reg        <= cnt_next;
        acc_reg        <= acc_next;
        aux_reg        <= aux_next;
        den_reg        <= den_next;
        res_reg        <= res_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    `ASSERT_NEXT(a_op_blocks_input, in_acc && in_is_op, !s_tready,
        "operator word did not stall input")
    `ASSERT_NEXT(a_push_lands, in_acc && (in_mode == MODE_PUSH),
        stack_reg[0] == $past(s_tdata), "pushed word not at bottom")
    `ASSERT_NEXT(a_pop_clears_top, commit && !err_reg, stack_reg[STACK_DEPTH-1] == '0,
        "top entry not cleared on pop")
    `ASSERT_SAME(a_err_zero, m_tvalid && m_tuser, m_tdata == '0,
        "error result is not zero")
    `ASSERT_SAME(a_div_count, state_reg == ST_DIV, cnt_reg <= DIV_LAST,
        "divide step count overran")

endmodule

// ----- verif/rpn_checker.sv -----
`timescale 1ns / 1ps

module rpn_checker
    import rpncalc_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int FRAC  = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  logic  s_tready,
    input  word_t s_tdata,
    input  logic  [2:0] s_tuser,
    input  logic  m_tvalid,
    input  logic  m_tready,
    input  word_t m_tdata,
    input  logic  m_tuser,
    output int    fail_count,
    output int    outstanding
);

    localparam int     ERR_SHOWN = 100;
    localparam longint SUM_MAX   = 64'sd2147483647;
    localparam longint SUM_MIN   = -64'sd2147483648;

    typedef logic signed [WORD_W-1:0] q_t;
    typedef struct packed {
        q_t   value;
        logic div_zero;
    } calc_out_t;

    q_t        calc_stack [DEPTH];
    calc_out_t expected_q [$];

    // sign a magnitude and clamp it to the word range
    function automatic q_t clamp_mag(input logic [63:0] mag, input logic neg);
        logic [63:0] twos;
        twos = 64'd0 - mag;
        if (neg) begin
            return (mag >= 64'h8000_0000) ? q_t'(Q_MIN) : q_t'(twos[31:0]);
        end
        return (mag > 64'h7fff_ffff) ? q_t'(Q_MAX) : q_t'(mag[31:0]);
    endfunction

    function automatic q_t clamp_sum(input longint s);
        if (s > SUM_MAX) return q_t'(Q_MAX);
        if (s < SUM_MIN) return q_t'(Q_MIN);
        return q_t'(s[31:0]);
    endfunction

    // product rounded to nearest, ties away from zero
    function automatic q_t q_product(input q_t a, input q_t b);
        longint      p;
        logic [63:0] m;
        p = longint'(a) * longint'(b);
        m = (p < 0) ? 64'(-p) : 64'(p);
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return clamp_mag(m, p < 0);
    endfunction

    // b is never zero here
    function automatic q_t q_quotient(input q_t a, input q_t b);
        longint      la, lb;
        logic [63:0] num, den;
        la  = a;
        lb  = b;
        num = 64'((la < 0) ? -la : la) << FRAC;
        den = 64'((lb < 0) ? -lb : lb);
        return clamp_mag((64'd2 * num + den) / (64'd2 * den), (a < 0) != (b < 0));
    endfunction

    always @(posedge aclk) begin : watch
        q_t        left, right, res;
        calc_out_t want;
        if (!aresetn) begin
            foreach (calc_stack[i]) calc_stack[i] = '0;
            expected_q.delete();
            outstanding <= 0;
        end else begin
            // compare first so a word accepted at this edge is never matched here
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < ERR_SHOWN)
                        $error("result word with nothing expected: result %h status %b",
                               m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.value) begin
                        if (fail_count < ERR_SHOWN)
                            $error("result mismatch: expected %h, got %h", want.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.div_zero) begin
                        if (fail_count < ERR_SHOWN)
                            $error("status mismatch: expected %b, got %b",
                                   want.div_zero, m_tuser);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    MODE_PUSH: begin
                        for (int i = DEPTH - 1; i > 0; i--) calc_stack[i] = calc_stack[i - 1];
                        calc_stack[0] = q_t'(s_tdata);
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                        left  = calc_stack[1];
                        right = calc_stack[0];
                        if (s_tuser == MODE_DIV && right == 0) begin
                            // stack stays as it was
                            expected_q.push_back('{value: '0, div_zero: 1'b1});
                        end else begin
                            case (s_tuser)
                                MODE_ADD: res = clamp_sum(longint'(left) + longint'(right));
                                MODE_SUB: res = clamp_sum(longint'(left) - longint'(right));
                                MODE_MUL: res = q_product(left, right);
                                default:  res = q_quotient(left, right);
                            endcase
                            for (int i = 1; i < DEPTH - 1; i++) calc_stack[i] = calc_stack[i + 1];
                            calc_stack[DEPTH - 1] = '0;
                            calc_stack[0]         = res;
                            expected_q.push_back('{value: res, div_zero: 1'b0});
                        end
                    end
                    default: ;  // unused codes are dropped
                endcase
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rpncalc_pkg::*;

    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam int         DIR_N        = 25;
    localparam int         RAND_WORDS   = 1550;

    typedef struct packed {
        logic [2:0] md;
        word_t      val;
    } stim_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PERIODIC} rx_style_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    word_t      s_tdata  = '0;
    logic [2:0] s_tuser  = MODE_PUSH;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    word_t      m_tdata;
    logic       m_tuser;
    int         fail_count;
    int         outstanding;

    int         rx_cycle = 0;
    rx_style_t  rx_style = RX_ALWAYS;

    // saturation corners, rounding ties, divide by zero, unused codes, divide overflow
    stim_t directed [DIR_N] = '{
        '{MODE_ADD,     32'h0000_0000},
        '{MODE_DIV,     32'h0000_0000},
        '{MODE_PUSH,    32'h7fff_ffff},
        '{MODE_PUSH,    32'h7fff_ffff},
        '{MODE_ADD,     32'h0000_0000},
        '{MODE_PUSH,    32'h8000_0000},
        '{MODE_SUB,     32'h0000_0000},
        '{MODE_PUSH,    32'h8000_0000},
        '{MODE_MUL,     32'h0000_0000},
        '{MODE_PUSH,    32'h0000_0001},
        '{MODE_PUSH,    32'h0000_8000},
        '{MODE_MUL,     32'h0000_0000},
        '{MODE_PUSH,    32'hffff_8000},
        '{MODE_MUL,     32'h0000_0000},
        '{MODE_PUSH,    32'h0000_0000},
        '{MODE_DIV,     32'h0000_0000},
        '{MODE_SPARE_5, 32'hffff_ffff},
        '{MODE_SPARE_6, 32'hffff_ffff},
        '{MODE_SPARE_7, 32'hffff_ffff},
        '{MODE_PUSH,    32'h8000_0000},
        '{MODE_PUSH,    32'hffff_ffff},
        '{MODE_DIV,     32'h0000_0000},
        '{MODE_PUSH,    32'h0003_0000},
        '{MODE_DIV,     32'h0000_0000},
        '{MODE_SUB,     32'h0000_0000}
    };

    rpn_four_level_stack_calculator_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rpn_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #2 aclk = ~aclk;

    // result side backpressure: rx_style is redrawn at random as rx_cycle counts on
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 255) rx_style <= rx_style_t'($urandom_range(0, 3));
        case (rx_style)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            RX_SELDOM: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= (rx_cycle % 16) >= 12;
        endcase
    end

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 48) return MODE_PUSH;
        if (r < 60) return MODE_ADD;
        if (r < 72) return MODE_SUB;
        if (r < 84) return MODE_MUL;
        if (r < 96) return MODE_DIV;
        case (r % 3)
            0:       return MODE_SPARE_5;
            1:       return MODE_SPARE_6;
            default: return MODE_SPARE_7;
        endcase
    endfunction

    function automatic word_t pick_operand();
        int    v;
        word_t w;
        case ($urandom_range(0, 5))
            0: return word_t'($urandom());
            1: begin
                v = int'($urandom_range(0, 200)) - 100;
                return word_t'(v * 65536);
            end
            2: begin
                v = int'($urandom_range(0, 32'h3ffff)) - 32'h1ffff;
                return word_t'(v);
            end
            3: return '0;
            4: begin
                case ($urandom_range(0, 4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return 32'hffff_ffff;
                    3:       return 32'h0000_0001;
                    default: return 32'h0001_0000;
                endcase
            end
            default: begin
                w = word_t'($urandom()) >> $urandom_range(0, 31);
                return $urandom_range(0, 1) ? word_t'(-w) : w;
            end
        endcase
    endfunction

    // holds the word until the handshake edge
    task automatic send_word(input logic [2:0] md, input word_t val);
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int         sent;
        int         next_pause;
        int         burst_len;
        logic [2:0] md;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) send_word(directed[i].md, directed[i].val);
        hold_until_drained();

        sent       = 0;
        next_pause = 500;
        while (sent < RAND_WORDS) begin
            burst_len = $urandom_range(1, 16);
            repeat (burst_len) begin
                md = pick_mode();
                send_word(md, pick_operand());
                if (md <= MODE_DIV) sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            if (sent >= next_pause) begin
                hold_until_drained();
                next_pause += 500;
            end
        end

        hold_until_drained();
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rpncalc_pkg.sv
hdl/rpn_four_level_stack_calculator_unit.sv
verif/rpn_checker.sv
verif/tb_top.sv
